FILE: rtl/ptrs_pkg.sv
package ptrs_pkg;
  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_REG = 3'd1;
  localparam logic [2:0] CMD_SCAN = 3'd2;
  localparam logic [2:0] CMD_DUR = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;

  localparam logic [2:0] KIND_REG_ACK = 3'd0;
  localparam logic [2:0] KIND_DISPATCH = 3'd1;
  localparam logic [2:0] KIND_IDLE = 3'd2;
  localparam logic [2:0] KIND_DUR_ACK = 3'd3;
  localparam logic [2:0] KIND_STATS = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NO_TASK = 2'd2;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  task_id;
    logic [31:0] period_ticks;
    logic [7:0]  priority_req;
    logic [31:0] duration_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  task_id_res;
    logic [1:0]  status;
    logic        last;
    logic [31:0] max_us;
    logic [31:0] min_us;
    logic [31:0] sum_us;
    logic [31:0] exec_count;
    logic [31:0] overrun_count;
    logic [31:0] last_duration_us;
  } out_item_t;
endpackage

FILE: rtl/ptrs_if.sv
interface ptrs_in_if;
  import ptrs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ptrs_out_if;
  import ptrs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ptrs_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/ptrs_front.sv
module ptrs_front (
  input  logic                clk,
  input  logic                rst_n,
  ptrs_in_if.sink             in_ch,
  output logic                q_valid,
  input  logic                q_ready,
  output ptrs_pkg::in_item_t  q_data
);
  import ptrs_pkg::*;

  // two-entry queue, drops unknown commands and bare ticks stay in order
  in_item_t    buf_r [2];
  logic [1:0]  cnt_r;
  logic        wp_r, rp_r;
  logic        push, pop, known;

  always_comb begin
    known = (in_ch.data.cmd == CMD_TICK) || (in_ch.data.cmd == CMD_REG) ||
            (in_ch.data.cmd == CMD_SCAN) || (in_ch.data.cmd == CMD_DUR) ||
            (in_ch.data.cmd == CMD_QUERY);
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready && known;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = buf_r[rp_r];
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_ch.data;
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: rtl/ptrs_back.sv
module ptrs_back #(
  parameter int TASK_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                idle_en,
  input  logic                q_valid,
  output logic                q_ready,
  input  ptrs_pkg::in_item_t  q_data,
  ptrs_out_if.source          out_ch
);
  import ptrs_pkg::*;

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  // room for the sort's j index, which runs up to slots + 1
  localparam int CW = $clog2(TASK_SLOTS + 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SORT = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;

  logic [2:0]    state_r;
  logic [31:0]   tick_r;
  logic [CW-1:0] count_r;
  logic [31:0]   period_r [TASK_SLOTS];
  logic [7:0]    prio_r [TASK_SLOTS];
  logic [31:0]   lastrel_r [TASK_SLOTS];
  logic [31:0]   maxd_r [TASK_SLOTS];
  logic [31:0]   mind_r [TASK_SLOTS];
  logic [31:0]   totd_r [TASK_SLOTS];
  logic [31:0]   runc_r [TASK_SLOTS];
  logic [31:0]   ovr_r [TASK_SLOTS];
  logic [31:0]   recd_r [TASK_SLOTS];

  logic [IW-1:0] ready_r [TASK_SLOTS];
  logic [CW-1:0] n_r;
  logic [CW-1:0] i_r, j_r;
  logic          ov_valid_r, ov_valid_nxt;
  out_item_t     ov_r, ov_nxt;

  logic [IW-1:0] tid;
  logic          tid_ok;
  logic [IW-1:0] si;
  logic [31:0]   elapsed;
  logic          out_free;
  logic          take;

  assign tid = IW'(q_data.task_id);
  assign tid_ok = (32'(q_data.task_id) < 32'(count_r))
                  && (32'(q_data.task_id) < 32'(TASK_SLOTS));
  assign si = i_r[IW-1:0];
  assign elapsed = tick_r - lastrel_r[si];
  assign out_free = !ov_valid_r || out_ch.ready;
  assign q_ready = (state_r == S_IDLE) && out_free;
  assign take = (state_r == S_IDLE) && q_valid && out_free;
  assign out_ch.valid = ov_valid_r;
  assign out_ch.data = ov_r;

  always_comb begin
    ov_valid_nxt = ov_valid_r && !out_ch.ready;
    ov_nxt = ov_r;
    if (take) begin
      ov_nxt = '0;
      case (q_data.cmd)
        CMD_REG: begin
          ov_valid_nxt = 1'b1;
          ov_nxt.kind = KIND_REG_ACK;
          if (count_r >= CW'(TASK_SLOTS)) ov_nxt.status = ST_FULL;
          else ov_nxt.task_id_res = 3'(count_r);
        end
        CMD_DUR: begin
          ov_valid_nxt = 1'b1;
          ov_nxt.kind = KIND_DUR_ACK;
          ov_nxt.task_id_res = q_data.task_id;
          if (!tid_ok) ov_nxt.status = ST_NO_TASK;
        end
        CMD_QUERY: begin
          ov_valid_nxt = 1'b1;
          ov_nxt.kind = KIND_STATS;
          ov_nxt.task_id_res = q_data.task_id;
          if (!tid_ok) begin
            ov_nxt.status = ST_NO_TASK;
          end else begin
            ov_nxt.max_us = maxd_r[tid];
            ov_nxt.min_us = mind_r[tid];
            ov_nxt.sum_us = totd_r[tid];
            ov_nxt.exec_count = runc_r[tid];
            ov_nxt.overrun_count = ovr_r[tid];
            ov_nxt.last_duration_us = recd_r[tid];
          end
        end
        default: ;
      endcase
    end else if ((state_r == S_EMIT) && out_free) begin
      if (n_r == '0) begin
        if (idle_en) begin
          ov_valid_nxt = 1'b1;
          ov_nxt = '0;
          ov_nxt.kind = KIND_IDLE;
          ov_nxt.last = 1'b1;
        end
      end else begin
        ov_valid_nxt = 1'b1;
        ov_nxt = '0;
        ov_nxt.kind = KIND_DISPATCH;
        ov_nxt.task_id_res = 3'(ready_r[i_r[IW-1:0]]);
        ov_nxt.last = (i_r + CW'(1) == n_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_r <= '0;
      count_r <= '0;
      ov_valid_r <= 1'b0;
      for (int k = 0; k < TASK_SLOTS; k++) begin
        maxd_r[k] <= '0;
        mind_r[k] <= ALL_ONES;
        totd_r[k] <= '0;
        runc_r[k] <= '0;
        ovr_r[k] <= '0;
        recd_r[k] <= '0;
      end
    end else begin
      ov_valid_r <= ov_valid_nxt;
      ov_r <= ov_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            case (q_data.cmd)
              CMD_TICK: tick_r <= tick_r + 32'd1;
              CMD_REG: begin
                if (count_r < CW'(TASK_SLOTS)) begin
                  period_r[count_r[IW-1:0]] <= q_data.period_ticks;
                  prio_r[count_r[IW-1:0]] <= q_data.priority_req;
                  lastrel_r[count_r[IW-1:0]] <= '0;
                  count_r <= count_r + CW'(1);
                end
              end
              CMD_SCAN: begin
                i_r <= '0;
                n_r <= '0;
                state_r <= S_SCAN;
              end
              CMD_DUR: begin
                if (tid_ok) begin
                  recd_r[tid] <= q_data.duration_us;
                  totd_r[tid] <= totd_r[tid] + q_data.duration_us;
                  runc_r[tid] <= runc_r[tid] + 32'd1;
                  if (q_data.duration_us > maxd_r[tid]) maxd_r[tid] <= q_data.duration_us;
                  if (q_data.duration_us < mind_r[tid]) mind_r[tid] <= q_data.duration_us;
                end
              end
              default: ;
            endcase
          end
        end
        // one slot per cycle
        S_SCAN: begin
          if (i_r >= count_r) begin
            i_r <= '0;
            j_r <= CW'(1);
            state_r <= S_SORT;
          end else begin
            if (lastrel_r[si] == 32'd0) begin
              lastrel_r[si] <= tick_r;
              ready_r[n_r[IW-1:0]] <= si;
              n_r <= n_r + CW'(1);
            end else if (elapsed >= period_r[si]) begin
              if (elapsed >= {period_r[si][30:0], 1'b0}) ovr_r[si] <= ovr_r[si] + 32'd1;
              lastrel_r[si] <= tick_r;
              ready_r[n_r[IW-1:0]] <= si;
              n_r <= n_r + CW'(1);
            end
            i_r <= i_r + CW'(1);
          end
        end
        // exchange sort, one compare per cycle
        S_SORT: begin
          if (i_r >= n_r) begin
            i_r <= '0;
            state_r <= S_EMIT;
          end else if (j_r >= n_r) begin
            i_r <= i_r + CW'(1);
            j_r <= i_r + CW'(2);
          end else begin
            if (prio_r[ready_r[j_r[IW-1:0]]] > prio_r[ready_r[i_r[IW-1:0]]]) begin
              ready_r[i_r[IW-1:0]] <= ready_r[j_r[IW-1:0]];
              ready_r[j_r[IW-1:0]] <= ready_r[i_r[IW-1:0]];
            end
            j_r <= j_r + CW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (n_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              i_r <= i_r + CW'(1);
              if (i_r + CW'(1) == n_r) state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/periodic_task_release_scheduler_unit.sv
// channel | dir | payload
// in_     | in  | cmd, task_id, period_ticks, priority_req, duration_us
// out_    | out | kind, task_id_res, status, last, statistics
// cfg_    | in  | idle_output_enabled
// a register, duration or query item is written into the output register when the back end takes it
// a scan holds the back end through a slot walk over the registered tasks, an exchange
// sort of the released ones, and the emit
// rst_n clears time, task count and statistics; task tables fill on register
// a full output register holds the back end; the queue accepts until its 2 entries fill
module periodic_task_release_scheduler_unit #(
  parameter int TASK_SLOTS = 8
) (
  input logic     clk,
  input logic     rst_n,
  ptrs_in_if.sink in_ch,
  ptrs_out_if.source out_ch,
  ptrs_cfg_if.sink cfg_ch
);
  import ptrs_pkg::*;

  logic     idle_en_r;
  logic     q_valid, q_ready;
  in_item_t q_data;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) idle_en_r <= 1'b0;
    else if (cfg_ch.valid) idle_en_r <= cfg_ch.data;
  end

  ptrs_front u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_ready, .q_data
  );

  ptrs_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
    .clk, .rst_n, .idle_en(idle_en_r), .q_valid, .q_ready, .q_data, .out_ch
  );
endmodule

FILE: tb/tb_periodic_task_release_scheduler_unit.sv
module tb_periodic_task_release_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ptrs_pkg::*;

  localparam int SLOTS = 8;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ptrs_in_if in_ch();
  ptrs_out_if out_ch();
  ptrs_cfg_if cfg_ch();

  periodic_task_release_scheduler_unit #(.TASK_SLOTS(SLOTS)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler state mirror
  logic        idle_en;
  logic [31:0] now_ms;
  int unsigned n_tasks;
  logic [31:0] period_q [SLOTS];
  logic [7:0]  prio_q [SLOTS];
  logic [31:0] released_at [SLOTS];
  logic [31:0] dur_max [SLOTS];
  logic [31:0] dur_min [SLOTS];
  logic [31:0] dur_total [SLOTS];
  logic [31:0] runs [SLOTS];
  logic [31:0] late_count [SLOTS];
  logic [31:0] dur_recent [SLOTS];

  out_item_t pending_results[$];
  int unsigned mismatches = 0;
  longint cycles = 0;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;

  function automatic out_item_t head(logic [2:0] kind, logic [2:0] id, logic [1:0] st,
                                     logic lst);
    out_item_t r;
    r = '0;
    r.kind = kind;
    r.task_id_res = id;
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  task automatic predict_schedule(in_item_t it);
    int unsigned order [SLOTS];
    int unsigned n;
    int unsigned t;
    logic [31:0] elapsed;
    out_item_t r;
    n = 0;
    case (it.cmd)
      CMD_TICK: now_ms = now_ms + 1;
      CMD_REG: begin
        if (n_tasks >= SLOTS) begin
          pending_results.push_back(head(KIND_REG_ACK, 3'd0, ST_FULL, 1'b0));
        end else begin
          period_q[n_tasks] = it.period_ticks;
          prio_q[n_tasks] = it.priority_req;
          released_at[n_tasks] = '0;
          pending_results.push_back(head(KIND_REG_ACK, n_tasks[2:0], ST_OK, 1'b0));
          n_tasks++;
        end
      end
      CMD_SCAN: begin
        for (int i = 0; i < n_tasks; i++) begin
          if (released_at[i] == 0) begin
            released_at[i] = now_ms;
            order[n++] = i;
          end else begin
            elapsed = now_ms - released_at[i];
            if (elapsed >= period_q[i]) begin
              if (elapsed >= 32'(period_q[i] * 32'd2)) late_count[i] = late_count[i] + 1;
              released_at[i] = now_ms;
              order[n++] = i;
            end
          end
        end
        // exchange sort, not stable on equal priority
        for (int i = 0; i < n; i++)
          for (int j = i + 1; j < n; j++)
            if (prio_q[order[j]] > prio_q[order[i]]) begin
              t = order[i];
              order[i] = order[j];
              order[j] = t;
            end
        if (n == 0 && idle_en)
          pending_results.push_back(head(KIND_IDLE, 3'd0, ST_OK, 1'b1));
        for (int i = 0; i < n; i++)
          pending_results.push_back(head(KIND_DISPATCH, order[i][2:0], ST_OK, i + 1 == n));
      end
      CMD_DUR: begin
        if (it.task_id >= n_tasks) begin
          pending_results.push_back(head(KIND_DUR_ACK, it.task_id, ST_NO_TASK, 1'b0));
        end else begin
          dur_recent[it.task_id] = it.duration_us;
          dur_total[it.task_id] = dur_total[it.task_id] + it.duration_us;
          runs[it.task_id] = runs[it.task_id] + 1;
          if (it.duration_us > dur_max[it.task_id]) dur_max[it.task_id] = it.duration_us;
          if (it.duration_us < dur_min[it.task_id]) dur_min[it.task_id] = it.duration_us;
          pending_results.push_back(head(KIND_DUR_ACK, it.task_id, ST_OK, 1'b0));
        end
      end
      CMD_QUERY: begin
        if (it.task_id >= n_tasks) begin
          pending_results.push_back(head(KIND_STATS, it.task_id, ST_NO_TASK, 1'b0));
        end else begin
          r = head(KIND_STATS, it.task_id, ST_OK, 1'b0);
          r.max_us = dur_max[it.task_id];
          r.min_us = dur_min[it.task_id];
          r.sum_us = dur_total[it.task_id];
          r.exec_count = runs[it.task_id];
          r.overrun_count = late_count[it.task_id];
          r.last_duration_us = dur_recent[it.task_id];
          pending_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic mismatch(string what, out_item_t exp_r, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h", what, exp_r, got);
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        mismatch("unexpected item", '0, got);
      end else begin
        exp_r = pending_results.pop_front();
        if (got.kind !== exp_r.kind || got.task_id_res !== exp_r.task_id_res ||
            got.status !== exp_r.status || got.last !== exp_r.last)
          mismatch("head", exp_r, got);
        else if (got.max_us !== exp_r.max_us || got.min_us !== exp_r.min_us ||
                 got.sum_us !== exp_r.sum_us || got.exec_count !== exp_r.exec_count ||
                 got.overrun_count !== exp_r.overrun_count ||
                 got.last_duration_us !== exp_r.last_duration_us)
          mismatch("statistics", exp_r, got);
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      case ((cycles / 300) % 3)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  initial begin
    wait (stim_done == 1'b0 && rst_n);
    repeat (200) @(posedge clk);
    long_hold = 1'b1;
    repeat (150) @(posedge clk);
    long_hold = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_schedule(it);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_idle_enable(logic v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    idle_en = v;
    @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [2:0] c, logic [2:0] id, logic [31:0] per,
                                  logic [7:0] pr, logic [31:0] dur);
    in_item_t it;
    it.cmd = c;
    it.task_id = id;
    it.period_ticks = per;
    it.priority_req = pr;
    it.duration_us = dur;
    return it;
  endfunction

  function automatic in_item_t rand_item(int unsigned mode);
    in_item_t it;
    int unsigned p;
    it = mk(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom,
            8'($urandom), $urandom);
    p = $urandom_range(0, 99);
    if (mode == 0) begin
      // mostly well-formed traffic: ticks and scans dominate, short periods
      if (p < 40) it.cmd = CMD_TICK;
      else if (p < 62) it.cmd = CMD_SCAN;
      else if (p < 78) it.cmd = CMD_DUR;
      else if (p < 92) it.cmd = CMD_QUERY;
      else if (p < 97) it.cmd = CMD_REG;
      if ($urandom_range(0, 3) != 0) it.period_ticks = $urandom_range(0, 6);
      if ($urandom_range(0, 3) != 0 && n_tasks > 0)
        it.task_id = 3'($urandom_range(0, n_tasks - 1));
    end
    return it;
  endfunction

  // directed rows: known results checked inline, rest via predictor
  typedef struct {
    in_item_t  it;
    bit        known;
    out_item_t res;
  } row_t;

  initial begin
    row_t rows[$];
    int unsigned burst;
    int unsigned sent;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    idle_en = 1'b0;
    now_ms = '0;
    n_tasks = 0;
    for (int i = 0; i < SLOTS; i++) begin
      period_q[i] = '0; prio_q[i] = '0; released_at[i] = '0;
      dur_max[i] = '0; dur_min[i] = ALL_ONES; dur_total[i] = '0;
      runs[i] = '0; late_count[i] = '0; dur_recent[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back('{mk(CMD_QUERY, 3'd0, 0, 0, 0), 1, head(KIND_STATS, 3'd0, ST_NO_TASK, 0)});
    rows.push_back('{mk(CMD_DUR, 3'd7, 0, 0, ALL_ONES), 1,
                     head(KIND_DUR_ACK, 3'd7, ST_NO_TASK, 0)});
    rows.push_back('{mk(CMD_SCAN, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_REG, 0, 32'd0, 8'd0, 0), 1, head(KIND_REG_ACK, 3'd0, ST_OK, 0)});
    rows.push_back('{mk(CMD_REG, 0, ALL_ONES, 8'hFF, 0), 1,
                     head(KIND_REG_ACK, 3'd1, ST_OK, 0)});
    rows.push_back('{mk(CMD_REG, 0, 32'h8000_0001, 8'd7, 0), 0, '0});
    // scan at tick zero keeps tasks new
    rows.push_back('{mk(CMD_SCAN, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_SCAN, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_REG, 0, 32'd2, 8'd7, 0), 0, '0});
    rows.push_back('{mk(CMD_REG, 0, 32'd1, 8'd7, 0), 0, '0});
    rows.push_back('{mk(CMD_REG, 0, 32'd3, 8'd200, 0), 0, '0});
    rows.push_back('{mk(CMD_REG, 0, 32'd1, 8'd7, 0), 0, '0});
    rows.push_back('{mk(CMD_REG, 0, 32'd5, 8'd1, 0), 0, '0});
    rows.push_back('{mk(CMD_REG, 0, 32'd4, 8'd9, 0), 1, head(KIND_REG_ACK, 3'd0, ST_FULL, 0)});
    rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_SCAN, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_DUR, 3'd1, 0, 0, 32'd0), 0, '0});
    rows.push_back('{mk(CMD_DUR, 3'd1, 0, 0, ALL_ONES), 0, '0});
    rows.push_back('{mk(CMD_QUERY, 3'd1, 0, 0, 0), 0, '0});
    rows.push_back('{mk(3'd5, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(3'd7, 3'd7, ALL_ONES, 8'hFF, ALL_ONES), 0, '0});
    rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_SCAN, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_QUERY, 3'd2, 0, 0, 0), 0, '0});

    foreach (rows[k]) begin
      send_item(rows[k].it);
      if (rows[k].known && pending_results.size() != 0 &&
          pending_results[$] !== rows[k].res)
        mismatch("directed", rows[k].res, pending_results[$]);
      if (k == 2) begin
        drain();
        write_idle_enable(1'b1);
      end
    end
    drain();

    // several settings of the idle output, small random phases
    for (int ph = 0; ph < 4; ph++) begin
      write_idle_enable(ph[0]);
      sent = 0;
      while (sent < 19) begin
        burst = $urandom_range(1, 10);
        for (int b = 0; b < burst && sent < 19; b++) begin
          send_item(rand_item($urandom_range(0, 9) == 0 ? 1 : 0));
          sent++;
        end
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
      end
      drain();
    end

    stim_done = 1'b1;
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
